/* rtl/core/mrt_pkg.sv */
package mrt_pkg;

  localparam int ENTRIES = 256;
  localparam int KEY_W   = 32;
  localparam int COUNT_W = 32;
  localparam int AMT_W   = 32;
  localparam int SPREAD_W = 32;

  // two-level reduction tree over the cell row
  localparam int GROUP  = 16;
  localparam int NGROUP = (ENTRIES + GROUP - 1) / GROUP;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // state a cell shows to its neighbors
  typedef struct packed {
    logic               valid;
    logic               gt;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
  } link_t;

  // per-cell contribution to the reduction tree
  typedef struct packed {
    logic             match;
    logic             drop;
    logic [KEY_W-1:0] hi;
  } red_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic             cmp;
    logic             apply;
    cmd_e             op;
    logic [KEY_W-1:0] key;
    logic [AMT_W-1:0] amount;
    logic             any_match;
    logic             rem_drop;
    logic             ins_shift;
  } ctl_t;

endpackage

/* rtl/core/mrt_cell.sv */
module mrt_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mrt_pkg::ctl_t  ctl_i,
  input  mrt_pkg::link_t left_i,
  input  mrt_pkg::link_t right_i,
  output mrt_pkg::link_t self_o,
  output mrt_pkg::red_t  leaf_o
);

  logic                        valid_q, valid_d;
  logic [mrt_pkg::KEY_W-1:0]   key_q, key_d;
  logic [mrt_pkg::COUNT_W-1:0] count_q, count_d;
  logic                        match_q, gt_q, drop_q, last_q;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    count_d = count_q;
    if (ctl_i.apply) begin
      case (ctl_i.op)
        mrt_pkg::CMD_INSERT: begin
          if (ctl_i.any_match) begin
            if (match_q && (count_q != '1)) begin
              count_d = count_q + mrt_pkg::COUNT_W'(1);
            end
          end else if (ctl_i.ins_shift && gt_q) begin
            if (!left_i.gt) begin
              valid_d = 1'b1;
              key_d   = ctl_i.key;
              count_d = mrt_pkg::COUNT_W'(1);
            end else begin
              valid_d = left_i.valid;
              key_d   = left_i.key;
              count_d = left_i.count;
            end
          end
        end
        mrt_pkg::CMD_REMOVE: begin
          if (ctl_i.rem_drop) begin
            if (gt_q || match_q) begin
              valid_d = right_i.valid;
              key_d   = right_i.key;
              count_d = right_i.count;
            end
          end else if (match_q) begin
            count_d = count_q - ctl_i.amount;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
      gt_q    <= 1'b0;
      drop_q  <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (ctl_i.cmp) begin
        match_q <= valid_q && (key_q == ctl_i.key);
        gt_q    <= !valid_q || (key_q > ctl_i.key);
        drop_q  <= valid_q && (key_q == ctl_i.key) && !(count_q > ctl_i.amount);
        last_q  <= valid_q && !right_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    count_q <= count_d;
  end

  assign self_o.valid = valid_q;
  assign self_o.gt    = gt_q;
  assign self_o.key   = key_q;
  assign self_o.count = count_q;

  assign leaf_o.match = match_q;
  assign leaf_o.drop  = drop_q;
  assign leaf_o.hi    = last_q ? key_q : '0;

endmodule

/* rtl/core/mrt_or_tree.sv */
module mrt_or_tree (
  input  logic          clk_i,
  input  mrt_pkg::red_t leaf_i [mrt_pkg::ENTRIES],
  output mrt_pkg::red_t root_o
);

  mrt_pkg::red_t grp_d [mrt_pkg::NGROUP];
  mrt_pkg::red_t grp_q [mrt_pkg::NGROUP];
  mrt_pkg::red_t root_d, root_q;

  always_comb begin
    for (int g = 0; g < mrt_pkg::NGROUP; g++) begin
      grp_d[g] = '0;
      for (int m = 0; m < mrt_pkg::GROUP; m++) begin
        if (g * mrt_pkg::GROUP + m < mrt_pkg::ENTRIES) begin
          grp_d[g] = mrt_pkg::red_t'(grp_d[g] | leaf_i[g * mrt_pkg::GROUP + m]);
        end
      end
    end
  end

  always_comb begin
    root_d = '0;
    for (int g = 0; g < mrt_pkg::NGROUP; g++) begin
      root_d = mrt_pkg::red_t'(root_d | grp_q[g]);
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q  <= grp_d;
    root_q <= root_d;
  end

  assign root_o = root_q;

endmodule

/* rtl/core/multiset_range_tracker.sv */
// Bounded multiset of keys kept as a sorted row of cells, smallest key in
// cell 0, used cells packed at the low end. Each cell holds one key and its
// saturating count.
// Input channel: in_valid_i / in_stall_o with cmd_i, key_i, amount_i.
// Output channel: out_valid_o / out_stall_i with status_o, spread_o.
// Every input beat yields exactly one output beat, in order.
// Flow: at the accept edge every cell compares its key against the beat;
// the registered group and root levels of the reduction tree collect
// match, drop and the largest key; then, in S_APPLY, the cells update
// (shift for insert or drop) and the result register loads. A new beat
// is taken only after the previous one has loaded its result, as the
// input stalls whenever the controller is not idle.
// A finished result waits in the output register while out_stall_i is high;
// the next beat is still accepted and runs up to its update cycle, where it
// holds until the output register frees.
// Reset marks every cell empty and clears the output register; no sweep.
module multiset_range_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] key_i,
  input  logic [31:0] amount_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] spread_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RED1,
    S_RED2,
    S_APPLY
  } state_e;

  state_e                      state_q;
  mrt_pkg::cmd_e               op_q;
  logic [mrt_pkg::KEY_W-1:0]   key_q;
  logic [mrt_pkg::AMT_W-1:0]   amount_q;
  logic                        out_valid_q;
  mrt_pkg::status_e            status_q, status_d;
  logic [mrt_pkg::SPREAD_W-1:0] spread_q, spread_d;

  mrt_pkg::ctl_t  ctl;
  mrt_pkg::link_t links [mrt_pkg::ENTRIES];
  mrt_pkg::link_t lefts [mrt_pkg::ENTRIES];
  mrt_pkg::link_t rights [mrt_pkg::ENTRIES];
  mrt_pkg::red_t  leaves [mrt_pkg::ENTRIES];
  mrt_pkg::red_t  root;

  logic accept, apply, idle, full;

  assign idle   = (state_q == S_IDLE);
  assign accept = in_valid_i && idle;
  assign apply  = (state_q == S_APPLY) && !(out_valid_q && out_stall_i);
  assign full   = links[mrt_pkg::ENTRIES-1].valid;

  always_comb begin
    ctl.cmp       = accept;
    ctl.apply     = apply;
    ctl.op        = idle ? mrt_pkg::cmd_e'(cmd_i) : op_q;
    ctl.key       = idle ? key_i[mrt_pkg::KEY_W-1:0] : key_q;
    ctl.amount    = idle ? amount_i : amount_q;
    ctl.any_match = root.match;
    ctl.rem_drop  = root.drop;
    ctl.ins_shift = !root.match && !full;
  end

  always_comb begin
    for (int i = 0; i < mrt_pkg::ENTRIES; i++) begin
      lefts[i]  = (i == 0) ? '0 : links[(i == 0) ? 0 : i - 1];
      rights[i] = (i == mrt_pkg::ENTRIES - 1) ? '0
                  : links[(i == mrt_pkg::ENTRIES - 1) ? i : i + 1];
    end
  end

  for (genvar i = 0; i < mrt_pkg::ENTRIES; i++) begin : g_cell
    mrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .left_i (lefts[i]),
      .right_i(rights[i]),
      .self_o (links[i]),
      .leaf_o (leaves[i])
    );
  end

  mrt_or_tree u_tree (
    .clk_i (clk_i),
    .leaf_i(leaves),
    .root_o(root)
  );

  always_comb begin
    status_d = mrt_pkg::ST_OK;
    spread_d = '0;
    case (op_q)
      mrt_pkg::CMD_INSERT: begin
        if (!root.match && full) begin
          status_d = mrt_pkg::ST_FULL;
        end
      end
      mrt_pkg::CMD_QUERY: begin
        if (!links[0].valid) begin
          status_d = mrt_pkg::ST_EMPTY;
        end else begin
          spread_d = mrt_pkg::SPREAD_W'(root.hi - links[0].key);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= mrt_pkg::CMD_INSERT;
      key_q       <= '0;
      amount_q    <= '0;
      out_valid_q <= 1'b0;
      status_q    <= mrt_pkg::ST_OK;
      spread_q    <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && !apply) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q     <= mrt_pkg::cmd_e'(cmd_i);
            key_q    <= key_i[mrt_pkg::KEY_W-1:0];
            amount_q <= amount_i;
            state_q  <= S_RED1;
          end
        end
        S_RED1: state_q <= S_RED2;
        S_RED2: state_q <= S_APPLY;
        S_APPLY: begin
          if (apply) begin
            out_valid_q <= 1'b1;
            status_q    <= status_d;
            spread_q    <= spread_d;
            state_q     <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign in_stall_o  = !idle;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign spread_o    = spread_q;

endmodule
